### sv/ewre_pkg.sv
// ----------------------------------------------------------------------------
// ewre_pkg - shared types and constants of the encoder speed estimator
// Field widths, register indexes, rounding shifts and the sequencer states.
// ----------------------------------------------------------------------------
package ewre_pkg;

   // Stream payload widths
   localparam int IN_WIDTH       = 32;
   localparam int SPEED_WIDTH    = 40;
   localparam int RSP_DATA_WIDTH = 2 * SPEED_WIDTH;
   localparam int RSP_USER_WIDTH = 1;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 24;

   // Register widths
   localparam int WINDOW_WIDTH = 8;
   localparam int GAIN_WIDTH   = 24;
   localparam int ALPHA_WIDTH  = 17;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_TICKS    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COUNT_INVERTED  = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPEED_GAIN      = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SMOOTHING_ALPHA = 4'd3;

   // Register reset values
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_TICKS_RESET    = 8'd10;
   localparam logic                    COUNT_INVERTED_RESET  = 1'b0;
   localparam logic [GAIN_WIDTH-1:0]   SPEED_GAIN_RESET      = 24'd384000;
   localparam logic [ALPHA_WIDTH-1:0]  SMOOTHING_ALPHA_RESET = 17'd13107;

   // Rounding: raw speed drops 8 bits, smoothing step drops 16 bits
   localparam int RAW_SHIFT    = 8;
   localparam int SMOOTH_SHIFT = 16;
   // Magnitude of the raw speed before saturation
   localparam int RAW_MAG_WIDTH = SPEED_WIDTH - 1;
   // Smoothing step magnitude: |delta| < 2^40, alpha < 2^17
   localparam int STEP_WIDTH = 42;
   // Signed sum of filtered speed and step
   localparam int UPDATE_WIDTH = STEP_WIDTH + 2;

   localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = 40'sh80_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ACCUM,
      ST_RAW_MAG,
      ST_RAW_MUL,
      ST_RAW_ROUND,
      ST_RAW_SIGN,
      ST_DELTA,
      ST_SM_MAG,
      ST_SM_MUL,
      ST_SM_ROUND,
      ST_SM_STEP,
      ST_OUTPUT
   } ewre_state_type;

endpackage

### sv/ewre_serial_mult.sv
// ----------------------------------------------------------------------------
// ewre_serial_mult - bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, LSB first; the product is flagged
// by a one-cycle done.
// ----------------------------------------------------------------------------
module ewre_serial_mult import ewre_pkg::*; #(
   parameter int MCAND_WIDTH = 40,
   parameter int MPLR_WIDTH  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [MCAND_WIDTH-1:0]            mcand,
   input  logic [MPLR_WIDTH-1:0]             mplr,
   output logic                              done,
   output logic [MCAND_WIDTH+MPLR_WIDTH-1:0] product
);

   localparam int PROD_WIDTH = MCAND_WIDTH + MPLR_WIDTH;
   localparam int CNT_WIDTH  = $clog2(MPLR_WIDTH + 1);

   logic [MCAND_WIDTH-1:0] mcand_ff, mcand_in;
   logic [MPLR_WIDTH-1:0]  mplr_ff, mplr_in;
   logic [PROD_WIDTH-1:0]  acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [MCAND_WIDTH:0]   partial;

   // add the selected multiplicand into the upper half, then shift right
   assign partial = {1'b0, acc_ff[PROD_WIDTH-1:MPLR_WIDTH]}
                  + (mplr_ff[0] ? {1'b0, mcand_ff} : {(MCAND_WIDTH+1){1'b0}});

   always_comb begin
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = mcand;
         mplr_in  = mplr;
         acc_in   = '0;
         cnt_in   = CNT_WIDTH'(MPLR_WIDTH);
      end else if (cnt_ff != '0) begin
         acc_in  = {partial, acc_ff[MPLR_WIDTH-1:1]};
         mplr_in = mplr_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### sv/encoder_windowed_rpm_ema.sv
// Sequencing: a tick that closes a window runs the raw-speed pass and then the
//   smoothing pass on the bit-serial multiplier; any other tick only the smoothing one.
// One req word is in work at a time: the next one is taken only after the last
//   has been loaded into the output slot.
// Reset: synchronous, active high; clears the sequencer, the count history,
//   window sum, tick count and both speeds, and loads the register defaults.
// ----------------------------------------------------------------------------
// encoder_windowed_rpm_ema - encoder speed estimator with EMA smoothing
// Differences cumulative encoder counts into a window sum, converts each
// closed window to rpm (Q8) and smooths it with an exponential average.
// ----------------------------------------------------------------------------
module encoder_windowed_rpm_ema import ewre_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // request stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [IN_WIDTH-1:0]        req_tdata,   // [31:0] encoder_total
   // response stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [39:0] speed_filtered,
                                                   // [79:40] speed_raw
   output logic [RSP_USER_WIDTH-1:0]  rsp_tuser,   // [0] window_done
   // register write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // Counts are sign-extended (or cut) to COUNT_WIDTH; the shared multiplier
   // is sized for the wider of |window sum| and |raw - filtered|.
   localparam int EXT_WIDTH  = (COUNT_WIDTH > IN_WIDTH) ? COUNT_WIDTH : IN_WIDTH;
   localparam int MC_WIDTH   = (COUNT_WIDTH > SPEED_WIDTH) ? COUNT_WIDTH : SPEED_WIDTH;
   localparam int PROD_WIDTH = MC_WIDTH + GAIN_WIDTH;
   localparam int DELTA_WIDTH = SPEED_WIDTH + 1;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   ewre_state_type state_ff, state_in;

   logic [WINDOW_WIDTH-1:0] window_ticks_ff, window_ticks_in;
   logic                    count_inverted_ff, count_inverted_in;
   logic [GAIN_WIDTH-1:0]   speed_gain_ff, speed_gain_in;
   logic [ALPHA_WIDTH-1:0]  smoothing_alpha_ff, smoothing_alpha_in;

   logic [COUNT_WIDTH-1:0]  cur_ff, cur_in;     // count of this tick
   logic [COUNT_WIDTH-1:0]  prev_ff, prev_in;   // count of the last tick
   logic [COUNT_WIDTH-1:0]  diff_ff, diff_in;
   logic [COUNT_WIDTH-1:0]  sum_ff, sum_in;     // open window sum
   logic [WINDOW_WIDTH-1:0] tick_ff, tick_in;
   logic                    done_ff, done_in;   // this tick closes a window
   logic                    neg_ff, neg_in;     // sign of the closed sum
   logic                    rsat_ff, rsat_in;
   logic [RAW_MAG_WIDTH-1:0] rmag_ff, rmag_in;
   logic signed [SPEED_WIDTH-1:0] raw_ff, raw_in;
   logic signed [SPEED_WIDTH-1:0] filt_ff, filt_in;
   logic signed [DELTA_WIDTH-1:0] delta_ff, delta_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_WIDTH-1:0] rsp_user_ff, rsp_user_in;

   // ---------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------
   logic                    req_accept;
   logic                    slot_free;
   logic                    rsp_load;
   logic                    mult_start;
   logic                    mult_done;
   logic [MC_WIDTH-1:0]     mult_mcand;
   logic [GAIN_WIDTH-1:0]   mult_mplr;
   logic [PROD_WIDTH-1:0]   mult_product;

   logic [EXT_WIDTH-1:0]    total_ext;
   logic [COUNT_WIDTH-1:0]  total_cur;
   logic [WINDOW_WIDTH-1:0] tick_inc;
   logic [COUNT_WIDTH-1:0]  sum_abs;
   logic [DELTA_WIDTH-1:0]  delta_abs;
   logic [PROD_WIDTH:0]     raw_round;
   logic [PROD_WIDTH:0]     sm_round;
   logic [SPEED_WIDTH-1:0]  raw_mag_ext;
   logic signed [UPDATE_WIDTH-1:0] filt_ext;
   logic signed [UPDATE_WIDTH-1:0] step_ext;
   logic signed [UPDATE_WIDTH-1:0] update;

   assign req_accept = req_tvalid && req_tready;
   // output slot is free when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign total_ext = EXT_WIDTH'($signed(req_tdata));
   assign total_cur = total_ext[COUNT_WIDTH-1:0];
   assign tick_inc  = tick_ff + 1'b1;
   assign sum_abs   = sum_ff[COUNT_WIDTH-1] ? COUNT_WIDTH'(~sum_ff + 1'b1) : sum_ff;
   assign delta_abs = delta_ff[DELTA_WIDTH-1] ? DELTA_WIDTH'(-delta_ff)
                                              : DELTA_WIDTH'(delta_ff);

   // round half away from zero on the magnitude
   assign raw_round = {1'b0, mult_product} + (PROD_WIDTH+1)'(1 << (RAW_SHIFT - 1));
   assign sm_round  = {1'b0, mult_product} + (PROD_WIDTH+1)'(1 << (SMOOTH_SHIFT - 1));

   assign raw_mag_ext = {1'b0, rmag_ff};
   assign filt_ext    = UPDATE_WIDTH'(filt_ff);
   assign step_ext    = $signed({2'b00, step_ff});
   assign update      = delta_ff[DELTA_WIDTH-1] ? (filt_ext - step_ext)
                                                : (filt_ext + step_ext);

   // shared multiplier: window sum times gain, then delta times alpha
   assign mult_mcand = (state_ff == ST_RAW_MAG) ? MC_WIDTH'(sum_abs)
                                                : MC_WIDTH'(delta_abs[SPEED_WIDTH-1:0]);
   assign mult_mplr  = (state_ff == ST_RAW_MAG) ? speed_gain_ff
                                                : GAIN_WIDTH'(smoothing_alpha_ff);

   ewre_serial_mult #(
      .MCAND_WIDTH (MC_WIDTH),
      .MPLR_WIDTH  (GAIN_WIDTH)
   ) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mult_start),
      .mcand   (mult_mcand),
      .mplr    (mult_mplr),
      .done    (mult_done),
      .product (mult_product)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept) state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_ACCUM;
         ST_ACCUM:     state_in = done_ff ? ST_RAW_MAG : ST_DELTA;
         ST_RAW_MAG:   state_in = ST_RAW_MUL;
         ST_RAW_MUL:   if (mult_done) state_in = ST_RAW_ROUND;
         ST_RAW_ROUND: state_in = ST_RAW_SIGN;
         ST_RAW_SIGN:  state_in = ST_DELTA;
         ST_DELTA:     state_in = ST_SM_MAG;
         ST_SM_MAG:    state_in = ST_SM_MUL;
         ST_SM_MUL:    if (mult_done) state_in = ST_SM_ROUND;
         ST_SM_ROUND:  state_in = ST_SM_STEP;
         ST_SM_STEP:   state_in = ST_OUTPUT;
         ST_OUTPUT:    if (slot_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      mult_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_RAW_MAG: mult_start = 1'b1;
         ST_SM_MAG:  mult_start = 1'b1;
         ST_OUTPUT:  rsp_load   = slot_free;
         default:    req_tready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Register writes
   // ---------------------------------------------------------------------
   always_comb begin
      window_ticks_in    = window_ticks_ff;
      count_inverted_in  = count_inverted_ff;
      speed_gain_in      = speed_gain_ff;
      smoothing_alpha_in = smoothing_alpha_ff;
      if (csr_valid && csr_ready) begin
         // keep the low bits of each register; ignore unknown indexes
         case (csr_index)
            REG_WINDOW_TICKS:    window_ticks_in    = csr_data[WINDOW_WIDTH-1:0];
            REG_COUNT_INVERTED:  count_inverted_in  = csr_data[0];
            REG_SPEED_GAIN:      speed_gain_in      = csr_data[GAIN_WIDTH-1:0];
            REG_SMOOTHING_ALPHA: smoothing_alpha_in = csr_data[ALPHA_WIDTH-1:0];
            default:             window_ticks_in    = window_ticks_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      diff_in  = diff_ff;
      sum_in   = sum_ff;
      tick_in  = tick_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      rsat_in  = rsat_ff;
      rmag_in  = rmag_ff;
      raw_in   = raw_ff;
      filt_in  = filt_ff;
      delta_in = delta_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            // negate the count first when the encoder is mounted reversed
            if (req_accept) begin
               cur_in = count_inverted_ff ? COUNT_WIDTH'(~total_cur + 1'b1) : total_cur;
            end
         end
         ST_DIFF: begin
            diff_in = cur_ff - prev_ff;
            prev_in = cur_ff;
            tick_in = tick_inc;
            // a window length of zero closes a window on every tick
            done_in = (tick_inc >= window_ticks_ff);
         end
         ST_ACCUM: begin
            sum_in = sum_ff + diff_ff;
         end
         ST_RAW_MAG: begin
            // the multiplier takes |sum| now; clear the open window
            neg_in  = sum_ff[COUNT_WIDTH-1];
            sum_in  = '0;
            tick_in = '0;
         end
         ST_RAW_ROUND: begin
            rmag_in = raw_round[RAW_SHIFT+RAW_MAG_WIDTH-1:RAW_SHIFT];
            rsat_in = |raw_round[PROD_WIDTH:RAW_SHIFT+RAW_MAG_WIDTH];
         end
         ST_RAW_SIGN: begin
            if (rsat_ff) begin
               raw_in = neg_ff ? SPEED_MIN : SPEED_MAX;
            end else begin
               raw_in = neg_ff ? $signed(SPEED_WIDTH'(~raw_mag_ext + 1'b1))
                               : $signed(raw_mag_ext);
            end
         end
         ST_DELTA: begin
            delta_in = DELTA_WIDTH'(raw_ff) - DELTA_WIDTH'(filt_ff);
         end
         ST_SM_ROUND: begin
            step_in = sm_round[SMOOTH_SHIFT+STEP_WIDTH-1:SMOOTH_SHIFT];
         end
         ST_SM_STEP: begin
            // saturate when the top bits are not all copies of the sign
            if (update[UPDATE_WIDTH-1:SPEED_WIDTH-1]
                == {(UPDATE_WIDTH-SPEED_WIDTH+1){update[SPEED_WIDTH-1]}}) begin
               filt_in = update[SPEED_WIDTH-1:0];
            end else begin
               filt_in = update[UPDATE_WIDTH-1] ? SPEED_MIN : SPEED_MAX;
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output slot: holds a finished word while the core takes the next one
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {raw_ff, filt_ff};
         rsp_user_in  = done_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         window_ticks_ff    <= WINDOW_TICKS_RESET;
         count_inverted_ff  <= COUNT_INVERTED_RESET;
         speed_gain_ff      <= SPEED_GAIN_RESET;
         smoothing_alpha_ff <= SMOOTHING_ALPHA_RESET;
         prev_ff            <= '0;
         sum_ff             <= '0;
         tick_ff            <= '0;
         raw_ff             <= '0;
         filt_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         window_ticks_ff    <= window_ticks_in;
         count_inverted_ff  <= count_inverted_in;
         speed_gain_ff      <= speed_gain_in;
         smoothing_alpha_ff <= smoothing_alpha_in;
         prev_ff            <= prev_in;
         sum_ff             <= sum_in;
         tick_ff            <= tick_in;
         raw_ff             <= raw_in;
         filt_ff            <= filt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      diff_ff     <= diff_in;
      done_ff     <= done_in;
      neg_ff      <= neg_in;
      rsat_ff     <= rsat_in;
      rmag_ff     <= rmag_in;
      delta_ff    <= delta_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### sv/ewre_checker.sv
// ----------------------------------------------------------------------------
// ewre_checker - port-level checks of the encoder speed estimator
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module ewre_checker import ewre_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [RSP_USER_WIDTH-1:0] rsp_tuser
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   // one word in flight in the core: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous word is still in work");

   // a response cannot appear the cycle after a request was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response appeared too early after a request");

   // reset leaves the response slot empty
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind encoder_windowed_rpm_ema ewre_checker u_ewre_checker (.*);
